/* rtl/ds5_pkg.sv */
`timescale 1ns / 1ps

package ds5_pkg;

  localparam int MAX_COLUMNS_DEF   = 1024;
  localparam int MAX_ROWS_DEF      = 1024;
  localparam int SAMPLE_BITS_DEF   = 24;
  localparam int FAC_FRAC_BITS_DEF = 16;

  localparam int FAC_BITS       = 16;
  localparam int CFG_COL_BITS   = 11;
  localparam int CFG_ROW_BITS   = 11;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [FAC_BITS-1:0]     FAC_RESET     = '0;
  localparam logic [CFG_COL_BITS-1:0] COLUMNS_RESET = 11'd1024;
  localparam logic [CFG_ROW_BITS-1:0] ROWS_RESET    = 11'd1024;

  // result buffer depth, covers the pipeline latency at full rate
  localparam int RESULT_DEPTH = 8;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FAC     = 2'd0,
    REG_COLUMNS = 2'd1,
    REG_ROWS    = 2'd2
  } cfg_reg_t;

endpackage

/* rtl/ds5_if.sv */
`timescale 1ns / 1ps

interface ds5_in_if import ds5_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] density_in;

  modport source (output valid, output density_in, input ready);
  modport sink (input valid, input density_in, output ready);
endinterface

interface ds5_out_if import ds5_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] density_out;
  logic                          frame_done;

  modport source (output valid, output density_out, output frame_done, input ready);
  modport sink (input valid, input density_out, input frame_done, output ready);
endinterface

/* rtl/ds5_ram.sv */
`timescale 1ns / 1ps

module ds5_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

/* rtl/ds5_fifo.sv */
`timescale 1ns / 1ps

module ds5_fifo import ds5_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int DEPTH       = RESULT_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [SAMPLE_BITS:0] push_data,
  output logic                 pop,
  ds5_out_if.source            results
);

  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [SAMPLE_BITS:0]  entries [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0]   count, count_next;
  logic [SAMPLE_BITS:0]  head;

  // no full check: the producer holds a credit for every entry
  assign pop  = results.valid && results.ready;
  assign head = entries[rd_ptr];

  assign results.valid       = (count != '0);
  assign results.density_out = head[SAMPLE_BITS:1];
  assign results.frame_done  = head[0];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (!push && pop) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

endmodule

/* rtl/diffusion_stencil_5pt.sv */
`timescale 1ns / 1ps

// Five-point diffusion stencil on a raster stream: top halo row, interior
// rows, bottom halo row, each row columns_in_use samples. One sample is taken
// every clock cycle; the two previous rows sit in one dual-read row memory
// (older and middle row side by side), read at the current and the next column
// in the cycle a sample is taken and written back in the cycle after, with
// forwarding when the next sample hits the entry being written. The first two
// rows of a frame only fill the memory. From the third row on, every sample
// yields the updated value of the same column one row up, on the output via the
// s1, s2 and s3 registers and an eight-beat result buffer; input is held
// off only when that buffer and the pipeline together hold eight pending
// results. After reset the memory reads as zero above the highest column
// written so far, so no clearing pass is needed. The user must write the
// configuration only while no sample is in flight; the block does not enforce it.
module diffusion_stencil_5pt import ds5_pkg::*; #(
  parameter int MAX_COLUMNS   = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS      = MAX_ROWS_DEF,
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
  parameter int FAC_FRAC_BITS = FAC_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  ds5_in_if.sink                    samples,
  ds5_out_if.source                 results,
  input  logic                      wr_en,
  input  logic [CFG_INDEX_BITS-1:0] wr_index,
  input  logic [CFG_DATA_BITS-1:0]  wr_data
);

  localparam int COL_BITS  = $clog2(MAX_COLUMNS);
  localparam int FILL_BITS = $clog2(MAX_COLUMNS + 1);
  localparam int ROW_BITS  = $clog2(MAX_ROWS + 2);
  localparam int LAP_BITS  = SAMPLE_BITS + 3;
  localparam int PROD_BITS = LAP_BITS + FAC_BITS + 1;
  localparam int SUM_BITS  = PROD_BITS + 1;
  localparam int CRED_BITS = $clog2(RESULT_DEPTH + 1);

  localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // configuration
  logic [FAC_BITS-1:0]     fac;
  logic [CFG_COL_BITS-1:0] columns_in_use;
  logic [CFG_ROW_BITS-1:0] rows_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      fac            <= FAC_RESET;
      columns_in_use <= COLUMNS_RESET;
      rows_in_use    <= ROWS_RESET;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_FAC:     fac            <= wr_data[FAC_BITS-1:0];
        REG_COLUMNS: columns_in_use <= wr_data[CFG_COL_BITS-1:0];
        REG_ROWS:    rows_in_use    <= wr_data[CFG_ROW_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic [FILL_BITS-1:0] cols_eff, cols_last;
  logic [ROW_BITS-1:0]  rows_eff;

  always_comb begin
    if (columns_in_use < CFG_COL_BITS'(2)) begin
      cols_eff = FILL_BITS'(2);
    end else if (32'(columns_in_use) > MAX_COLUMNS) begin
      cols_eff = FILL_BITS'(MAX_COLUMNS);
    end else begin
      cols_eff = FILL_BITS'(columns_in_use);
    end
    if (rows_in_use == '0) begin
      rows_eff = ROW_BITS'(1);
    end else if (32'(rows_in_use) > MAX_ROWS) begin
      rows_eff = ROW_BITS'(MAX_ROWS);
    end else begin
      rows_eff = ROW_BITS'(rows_in_use);
    end
  end

  assign cols_last = cols_eff - 1'b1;

  // raster position and accept side
  logic [COL_BITS-1:0]  column_count, column_count_next;
  logic [ROW_BITS-1:0]  row_count, row_count_next;
  logic [COL_BITS-1:0]  col_cur;
  logic [COL_BITS:0]    col_plus;
  logic                 last_col, last_row, has_result;
  logic                 accept, pop;
  logic [CRED_BITS-1:0] credits;

  assign samples.ready = (32'(credits) < RESULT_DEPTH);
  assign accept        = samples.valid && samples.ready;

  always_comb begin
    if (FILL_BITS'(column_count) >= cols_eff) begin
      col_cur = COL_BITS'(cols_last);
    end else begin
      col_cur = column_count;
    end
    col_plus   = {1'b0, col_cur} + 1'b1;
    last_col   = (FILL_BITS'(col_cur) >= cols_last);
    last_row   = ({1'b0, row_count} >= ({1'b0, rows_eff} + 1'b1));
    has_result = (row_count >= ROW_BITS'(2));
  end

  always_comb begin
    column_count_next = col_cur + 1'b1;
    row_count_next    = row_count;
    if (last_col) begin
      column_count_next = '0;
      row_count_next    = last_row ? '0 : row_count + 1'b1;
    end
  end

  // pending results: in the pipeline or waiting in the result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else begin
      case ({accept && has_result, pop})
        2'b10:   credits <= credits + 1'b1;
        2'b01:   credits <= credits - 1'b1;
        default: credits <= credits;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // row memory: {older, middle} per column
  logic                       s1_valid, s1_result, s1_last_col, s1_frame_done;
  logic [COL_BITS-1:0]        s1_col;
  logic signed [SAMPLE_BITS-1:0] s1_x;
  logic                       s1_a_ok, s1_b_ok, s1_fwd_a, s1_fwd_b;
  logic [2*SAMPLE_BITS-1:0]   s1_fwd_data;
  logic [2*SAMPLE_BITS-1:0]   rd_data_a, rd_data_b, row_wr_data;
  logic [FILL_BITS-1:0]       fill;
  logic signed [SAMPLE_BITS-1:0] left_value;

  ds5_ram #(
    .WIDTH (2 * SAMPLE_BITS),
    .DEPTH (MAX_COLUMNS)
  ) u_rows (
    .clk       (clk),
    .we        (s1_valid),
    .wr_addr   (s1_col),
    .wr_data   (row_wr_data),
    .rd_addr_a (col_cur),
    .rd_addr_b (col_plus[COL_BITS-1:0]),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  always_ff @(posedge clk) begin
    s1_col        <= col_cur;
    s1_x          <= samples.density_in;
    s1_last_col   <= last_col;
    s1_result     <= has_result;
    s1_frame_done <= last_col && last_row;
    // entries above the fill mark were never written and read as zero
    s1_a_ok       <= (FILL_BITS'(col_cur) < fill);
    s1_b_ok       <= (32'(col_plus) < 32'(fill));
    s1_fwd_a      <= s1_valid && (s1_col == col_cur);
    s1_fwd_b      <= s1_valid && ({1'b0, s1_col} == col_plus);
    s1_fwd_data   <= row_wr_data;
  end

  logic [2*SAMPLE_BITS-1:0]      entry_a;
  logic signed [SAMPLE_BITS-1:0] center, up, left, right, right_raw;
  logic signed [LAP_BITS-1:0]    lap;

  always_comb begin
    if (s1_fwd_a) begin
      entry_a = s1_fwd_data;
    end else if (s1_a_ok) begin
      entry_a = rd_data_a;
    end else begin
      entry_a = '0;
    end
    if (s1_fwd_b) begin
      right_raw = s1_fwd_data[SAMPLE_BITS-1:0];
    end else if (s1_b_ok) begin
      right_raw = rd_data_b[SAMPLE_BITS-1:0];
    end else begin
      right_raw = '0;
    end
    center = entry_a[SAMPLE_BITS-1:0];
    up     = entry_a[2*SAMPLE_BITS-1:SAMPLE_BITS];
    right  = s1_last_col ? '0 : right_raw;
    left   = (s1_col == '0) ? '0 : left_value;
    lap    = LAP_BITS'(up) + LAP_BITS'(s1_x) + LAP_BITS'(left) + LAP_BITS'(right)
             - (LAP_BITS'(center) <<< 2);
  end

  assign row_wr_data = {center, s1_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      fill       <= '0;
      left_value <= '0;
    end else begin
      s1_valid <= accept;
      if (s1_valid) begin
        left_value <= center;
        if (FILL_BITS'(s1_col) >= fill) begin
          fill <= FILL_BITS'(s1_col) + 1'b1;
        end
      end
    end
  end

  // stage 2: scale by fac
  logic                          s2_valid, s2_frame_done;
  logic signed [LAP_BITS-1:0]    s2_lap;
  logic signed [SAMPLE_BITS-1:0] s2_center;
  logic signed [FAC_BITS:0]      fac_s;
  logic signed [PROD_BITS-1:0]   prod;

  always_ff @(posedge clk) begin
    s2_lap        <= lap;
    s2_center     <= center;
    s2_frame_done <= s1_frame_done;
  end

  assign fac_s = $signed({1'b0, fac});
  assign prod  = s2_lap * fac_s;

  // stage 3: floor shift, add, saturate
  logic                          s3_valid, s3_frame_done;
  logic signed [PROD_BITS-1:0]   s3_prod, scaled;
  logic signed [SAMPLE_BITS-1:0] s3_center, sat;
  logic signed [SUM_BITS-1:0]    sum;

  always_ff @(posedge clk) begin
    s3_prod       <= prod;
    s3_center     <= s2_center;
    s3_frame_done <= s2_frame_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1_result;
      s3_valid <= s2_valid;
    end
  end

  always_comb begin
    scaled = s3_prod >>> FAC_FRAC_BITS;
    sum    = SUM_BITS'(s3_center) + SUM_BITS'(scaled);
    if (sum > SUM_BITS'($signed(SAT_MAX))) begin
      sat = $signed(SAT_MAX);
    end else if (sum < SUM_BITS'($signed(SAT_MIN))) begin
      sat = $signed(SAT_MIN);
    end else begin
      sat = sum[SAMPLE_BITS-1:0];
    end
  end

  ds5_fifo #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DEPTH       (RESULT_DEPTH)
  ) u_results (
    .clk       (clk),
    .rst       (rst),
    .push      (s3_valid),
    .push_data ({sat, s3_frame_done}),
    .pop       (pop),
    .results   (results)
  );

endmodule

/* rtl/ds5_check.sv */
`timescale 1ns / 1ps

module ds5_check import ds5_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_density,
  input logic                   out_frame_done
);

  // nothing comes out right after reset
  assert property (@(posedge clk) disable iff (rst) $past(rst) |-> !out_valid)
    else $error("result beat right after reset");

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_density) && $stable(out_frame_done))
    else $error("stalled result beat changed");

  // input is only held off while results are waiting
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input held off with no result pending");

  // an empty result buffer fills from an input beat taken before, through the s1, s2 and s3 registers
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 4))
    else $error("result beat without matching input beat");

endmodule

bind diffusion_stencil_5pt ds5_check #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_ds5_check (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (samples.valid),
  .in_ready       (samples.ready),
  .out_valid      (results.valid),
  .out_ready      (results.ready),
  .out_density    (results.density_out),
  .out_frame_done (results.frame_done)
);
